/* rtl/core/ptrmx_pkg.sv */
// Shared types and constants for the persistent trie range max-xor block.
`default_nettype none
package ptrmx_pkg;
   localparam int OUT_BITS = 25;
   localparam int POS_BITS = 13;
   localparam int STAT_BITS = 2;

   // Result status codes
   localparam logic [STAT_BITS-1:0] STAT_OK = 2'd0;
   localparam logic [STAT_BITS-1:0] STAT_FULL = 2'd1;
   localparam logic [STAT_BITS-1:0] STAT_RANGE = 2'd2;

   // Request kinds
   localparam logic KIND_APPEND = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   typedef struct packed {
      logic             req_type;
      logic [24:0]      value_in;
      logic [POS_BITS-1:0] range_first;
      logic [POS_BITS-1:0] range_last;
   } req_word_type;

   typedef struct packed {
      logic [OUT_BITS-1:0]  max_xor;
      logic [STAT_BITS-1:0] status;
   } rsp_word_type;
endpackage
`default_nettype wire

/* rtl/core/ptrmx_if.sv */
// Valid/ready channel interface carrying one word.
`default_nettype none
interface ptrmx_if #(parameter type word_type = logic) ();
   logic     valid;
   logic     ready;
   word_type word;
   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface
`default_nettype wire

/* rtl/core/ptrmx_cell.sv */
// One trie level cell: owns the node store of one depth and steps one walk.
`default_nettype none
module ptrmx_cell #(
   parameter int LEVEL = 0,
   parameter int KEY_BITS = 25,
   parameter int NODE_BITS = 13,
   parameter int CNT_BITS = 14
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   // walk token from the level above
   input  wire logic                 tok_valid,
   input  wire logic                 tok_query,
   input  wire logic [KEY_BITS-1:0]  tok_key,
   input  wire logic [NODE_BITS-1:0] tok_hi,
   input  wire logic [NODE_BITS-1:0] tok_lo,
   input  wire logic [KEY_BITS-1:0]  tok_best,
   input  wire logic [NODE_BITS-1:0] tok_fill,
   output logic                      nxt_valid,
   output logic                      nxt_query,
   output logic [KEY_BITS-1:0]       nxt_key,
   output logic [NODE_BITS-1:0]      nxt_hi,
   output logic [NODE_BITS-1:0]      nxt_lo,
   output logic [KEY_BITS-1:0]       nxt_best,
   output logic [NODE_BITS-1:0]      nxt_fill
);
   // Node store of this depth: node n (1-based) was made by version n-1.
   // Node 0 is the empty node. Entries become valid as versions are added,
   // so the fill count stands in for clearing.
   localparam int DEPTH = 1 << NODE_BITS;
   logic [NODE_BITS-1:0] c0_mem [DEPTH];
   logic [NODE_BITS-1:0] c1_mem [DEPTH];

   logic [NODE_BITS-1:0] h0, h1, l0, l1, hn0, hn1, ln0, ln1;

   // read stage: registered read of the two nodes
   logic rd_valid_ff, rd_query_ff;
   logic [KEY_BITS-1:0] rd_key_ff, rd_best_ff;
   logic [NODE_BITS-1:0] rd_fill_ff, rd_hi_ff, rd_lo_ff;
   logic [NODE_BITS-1:0] hc0_ff, hc1_ff, lc0_ff, lc1_ff;

   always_ff @(posedge clock) begin
      hc0_ff <= c0_mem[tok_hi]; hc1_ff <= c1_mem[tok_hi];
      lc0_ff <= c0_mem[tok_lo]; lc1_ff <= c1_mem[tok_lo];
      rd_key_ff <= tok_key; rd_best_ff <= tok_best;
      rd_fill_ff <= tok_fill; rd_hi_ff <= tok_hi; rd_lo_ff <= tok_lo;
      rd_query_ff <= tok_query;
      if (reset) rd_valid_ff <= 1'b0;
      else rd_valid_ff <= tok_valid;
   end

   // the zero node reads as empty
   always_comb begin
      h0 = (rd_hi_ff == '0) ? '0 : hc0_ff;
      h1 = (rd_hi_ff == '0) ? '0 : hc1_ff;
      l0 = (rd_lo_ff == '0) ? '0 : lc0_ff;
      l1 = (rd_lo_ff == '0) ? '0 : lc1_ff;
   end

   // each node keeps the key count under each of its two links, so the
   // walk decides here without a lookup one level down
   logic [CNT_BITS-1:0] ch_cnt_h, ch_cnt_l;
   logic rbit, rwant;
   assign rbit = rd_key_ff[KEY_BITS-1-LEVEL];
   assign rwant = ~rbit;

   // edge-count memories: count of subtree under child link
   logic [CNT_BITS-1:0] e0_mem [DEPTH];
   logic [CNT_BITS-1:0] e1_mem [DEPTH];
   logic [CNT_BITS-1:0] he0_ff, he1_ff, le0_ff, le1_ff;
   logic [CNT_BITS-1:0] he0, he1, le0, le1;
   always_ff @(posedge clock) begin
      he0_ff <= e0_mem[tok_hi]; he1_ff <= e1_mem[tok_hi];
      le0_ff <= e0_mem[tok_lo]; le1_ff <= e1_mem[tok_lo];
   end
   assign he0 = (rd_hi_ff == '0) ? '0 : he0_ff;
   assign he1 = (rd_hi_ff == '0) ? '0 : he1_ff;
   assign le0 = (rd_lo_ff == '0) ? '0 : le0_ff;
   assign le1 = (rd_lo_ff == '0) ? '0 : le1_ff;
   assign ch_cnt_h = rwant ? he1 : he0;
   assign ch_cnt_l = rwant ? le1 : le0;

   // insert: new node rd_fill_ff copies prev (rd_hi_ff) and redirects one link
   always_ff @(posedge clock) begin
      if (rd_valid_ff && !rd_query_ff) begin
         if (rbit) begin
            c1_mem[rd_fill_ff] <= rd_fill_ff;
            c0_mem[rd_fill_ff] <= h0;
            e1_mem[rd_fill_ff] <= he1 + CNT_BITS'(1);
            e0_mem[rd_fill_ff] <= he0;
         end else begin
            c0_mem[rd_fill_ff] <= rd_fill_ff;
            c1_mem[rd_fill_ff] <= h1;
            e0_mem[rd_fill_ff] <= he0 + CNT_BITS'(1);
            e1_mem[rd_fill_ff] <= he1;
         end
      end
   end

   assign hn0 = h0; assign hn1 = h1; assign ln0 = l0; assign ln1 = l1;

   // hand to next level
   always_ff @(posedge clock) begin
      nxt_key <= rd_key_ff; nxt_fill <= rd_fill_ff;
      nxt_query <= rd_query_ff;
      if (rd_query_ff) begin
         if (ch_cnt_h > ch_cnt_l) begin
            nxt_best <= rd_best_ff | (KEY_BITS'(1) << (KEY_BITS-1-LEVEL));
            nxt_hi <= rwant ? hn1 : hn0;
            nxt_lo <= rwant ? ln1 : ln0;
         end else begin
            nxt_best <= rd_best_ff;
            nxt_hi <= rwant ? hn0 : hn1;
            nxt_lo <= rwant ? ln0 : ln1;
         end
      end else begin
         nxt_best <= rd_best_ff;
         nxt_hi <= rbit ? hn1 : hn0;
         nxt_lo <= rd_lo_ff;
      end
      if (reset) nxt_valid <= 1'b0;
      else nxt_valid <= rd_valid_ff;
   end
endmodule
`default_nettype wire

/* rtl/core/persistent_trie_range_max_xor.sv */
// Persistent trie range max-xor: a row of per-level cells with per-version roots.
// A walked word passes through one cell per key bit, each with a read stage and a step
// stage, before its result is captured; a rejected word goes straight to the output state.
// Throughput: one word at a time; req.ready stays low until the result has been taken.
// Reset: synchronous; version 0 (key zero) is inserted right after reset and
// req.ready rises once the walk of that insert has left the last cell.
`default_nettype none
module persistent_trie_range_max_xor #(
   parameter int KEY_BITS = 25,
   parameter int MAX_ITEMS = 4096
) (
   input wire logic clock,
   input wire logic reset,
   ptrmx_if.sink   req,
   ptrmx_if.source rsp
);
   import ptrmx_pkg::*;
   // node n of every level belongs to version n-1
   localparam int NODE_BITS = $clog2(MAX_ITEMS + 2);
   localparam int CNT_BITS = $clog2(MAX_ITEMS + 2);

   typedef enum logic [3:0] {
      ST_INIT = 4'b0001, ST_IDLE = 4'b0010, ST_WALK = 4'b0100, ST_OUT = 4'b1000
   } state_type;
   state_type state_ff, state_in;

   logic [KEY_BITS-1:0] prefix_ff;
   logic [NODE_BITS-1:0] count_ff;
   logic [OUT_BITS-1:0] res_xor_ff;
   logic [STAT_BITS-1:0] res_stat_ff;

   // cell chain wiring
   logic                 v [KEY_BITS+1];
   logic                 q [KEY_BITS+1];
   logic [KEY_BITS-1:0]  k [KEY_BITS+1];
   logic [NODE_BITS-1:0] h [KEY_BITS+1];
   logic [NODE_BITS-1:0] lo [KEY_BITS+1];
   logic [KEY_BITS-1:0]  b [KEY_BITS+1];
   logic [NODE_BITS-1:0] f [KEY_BITS+1];

   for (genvar i = 0; i < KEY_BITS; i++) begin : g_cell
      ptrmx_cell #(.LEVEL(i), .KEY_BITS(KEY_BITS), .NODE_BITS(NODE_BITS),
                   .CNT_BITS(CNT_BITS)) u_cell (
         .clock, .reset,
         .tok_valid(v[i]), .tok_query(q[i]), .tok_key(k[i]), .tok_hi(h[i]),
         .tok_lo(lo[i]), .tok_best(b[i]), .tok_fill(f[i]),
         .nxt_valid(v[i+1]), .nxt_query(q[i+1]), .nxt_key(k[i+1]),
         .nxt_hi(h[i+1]), .nxt_lo(lo[i+1]), .nxt_best(b[i+1]),
         .nxt_fill(f[i+1])
      );
   end

   // request decode; root of version j at every level is node j+1
   logic [KEY_BITS-1:0] val_m;
   logic is_q, bad_q, full_a;
   logic [POS_BITS-1:0] l_w, r_w;
   assign val_m = KEY_BITS'(req.word.value_in);
   assign is_q = (req.word.req_type == KIND_QUERY);
   assign l_w = req.word.range_first;
   assign r_w = req.word.range_last;
   assign bad_q = (l_w == '0) || (l_w > r_w) ||
                  ({{(32-POS_BITS){1'b0}}, r_w} > 32'(count_ff));
   assign full_a = (32'(count_ff) >= MAX_ITEMS);

   logic start;
   assign req.ready = (state_ff == ST_IDLE);
   assign start = req.valid && req.ready;
   logic init_go;
   logic init_done_ff;

   // token entering the first cell
   logic                 go_valid, go_query;
   logic [KEY_BITS-1:0]  go_key;
   logic [NODE_BITS-1:0] go_hi, go_lo, go_fill;

   always_comb begin
      go_valid = 1'b0; go_query = 1'b0; go_key = '0; go_hi = '0; go_lo = '0;
      go_fill = '0;
      init_go = (state_ff == ST_INIT) && !init_done_ff;
      if (init_go) begin
         go_valid = 1'b1; go_fill = NODE_BITS'(1);
      end else if (start && ((is_q && !bad_q) || (!is_q && !full_a))) begin
         go_valid = 1'b1;
         go_query = is_q;
         if (is_q) begin
            go_key = prefix_ff ^ val_m;
            go_hi = NODE_BITS'(r_w);
            go_lo = (l_w >= POS_BITS'(2)) ? NODE_BITS'(l_w - POS_BITS'(1)) : '0;
         end else begin
            go_key = prefix_ff ^ val_m;
            go_hi = count_ff + NODE_BITS'(1);
            go_fill = count_ff + NODE_BITS'(2);
         end
      end
   end

   assign v[0] = go_valid;
   assign q[0] = go_query;
   assign k[0] = go_key;
   assign h[0] = go_hi;
   assign lo[0] = go_lo;
   assign b[0] = '0;
   assign f[0] = go_fill;

   // control
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: if (v[KEY_BITS]) state_in = ST_IDLE;
         ST_IDLE: if (start) state_in = v[0] ? ST_WALK : ST_OUT;
         ST_WALK: if (v[KEY_BITS]) state_in = ST_OUT;
         ST_OUT:  if (rsp.ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT; prefix_ff <= '0; count_ff <= '0; init_done_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (init_go) init_done_ff <= 1'b1;
         if (start && !is_q && !full_a) begin
            prefix_ff <= prefix_ff ^ val_m;
            count_ff <= count_ff + NODE_BITS'(1);
         end
      end
   end

   // result capture
   always_ff @(posedge clock) begin
      if (start) begin
         res_xor_ff <= '0;
         res_stat_ff <= is_q ? (bad_q ? STAT_RANGE : STAT_OK)
                             : (full_a ? STAT_FULL : STAT_OK);
      end else if (state_ff == ST_WALK && v[KEY_BITS] && q[KEY_BITS]) begin
         res_xor_ff <= OUT_BITS'(b[KEY_BITS]);
      end
   end

   assign rsp.valid = (state_ff == ST_OUT);
   assign rsp.word.max_xor = res_xor_ff;
   assign rsp.word.status = res_stat_ff;
endmodule
`default_nettype wire
